>>> rtl/core/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// shared types, constants and controller/datapath command and status structs
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int CAPACITY   = 128;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int DATA_W     = 32;
  localparam int POS_W      = 7;
  localparam int CNT_OUT_W  = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_FND_RD,
    S_FND_CMP,
    S_DEL_RD,
    S_DEL_WR
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    RA_IDX_M1,
    RA_IDX,
    RA_IDX_P1
  } rd_sel_t;

  typedef enum logic {
    WA_IDX,
    WA_ZERO
  } wa_sel_t;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wd_sel_t;

  typedef enum logic [1:0] {
    PS_ZERO,
    PS_IDX,
    PS_HELD
  } pos_sel_t;

  typedef struct packed {
    logic     capture;
    idx_op_t  idx_op;
    cnt_op_t  cnt_op;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wa_sel_t  wa_sel;
    wd_sel_t  wd_sel;
    logic     pos_hold;
    logic     done;
    status_t  status;
    pos_sel_t pos_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic gt;
    logic eq;
    logic idx_is_one;
    logic last_scan;
    logic last_move;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/sle_ram.sv
// ----------------------------------------------------------------------------
// sle_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// sequencer for insert, search, delete and clear transactions
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ctrl
  import sle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_opcode,
  input  wire stat_t      stat,
  output logic            busy,
  output cmd_t            cmd
);

  state_t  state_r, state_nxt;
  logic    is_delete_r, is_delete_nxt;
  opcode_t op;

  assign op   = opcode_t'(in_opcode);
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      is_delete_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      is_delete_r <= is_delete_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    is_delete_nxt = is_delete_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          is_delete_nxt = (op == OP_DELETE);
          unique case (op)
            OP_INSERT: begin
              if (!stat.full && !stat.empty) state_nxt = S_INS_RD;
            end
            OP_SEARCH, OP_DELETE: begin
              if (!stat.empty) state_nxt = S_FND_RD;
            end
            OP_CLEAR: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD:  state_nxt = S_INS_CMP;
      S_INS_CMP: begin
        if (stat.gt) begin
          state_nxt = stat.idx_is_one ? S_INS_PUT : S_INS_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INS_PUT: state_nxt = S_IDLE;
      S_FND_RD:  state_nxt = S_FND_CMP;
      S_FND_CMP: begin
        if (stat.eq) begin
          state_nxt = (is_delete_r && !stat.last_scan) ? S_DEL_RD : S_IDLE;
        end else begin
          state_nxt = stat.last_scan ? S_IDLE : S_FND_RD;
        end
      end
      S_DEL_RD: state_nxt = S_DEL_WR;
      S_DEL_WR: state_nxt = stat.last_move ? S_IDLE : S_DEL_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '{capture: 1'b0, idx_op: IDX_HOLD, cnt_op: CNT_HOLD, rd_en: 1'b0,
            rd_sel: RA_IDX, wr_en: 1'b0, wa_sel: WA_IDX, wd_sel: WD_VALUE,
            pos_hold: 1'b0, done: 1'b0, status: STAT_OK, pos_sel: PS_ZERO};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          unique case (op)
            OP_INSERT: begin
              if (stat.full) begin
                cmd.done   = 1'b1;
                cmd.status = STAT_FULL;
              end else if (stat.empty) begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_ZERO;
                cmd.cnt_op = CNT_INC;
                cmd.done   = 1'b1;
              end else begin
                cmd.idx_op = IDX_COUNT;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              if (stat.empty) begin
                cmd.done   = 1'b1;
                cmd.status = STAT_EMPTY;
              end else begin
                cmd.idx_op = IDX_ZERO;
              end
            end
            OP_CLEAR: begin
              cmd.cnt_op = CNT_CLEAR;
              cmd.done   = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_IDX_M1;
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.gt) begin
          cmd.wd_sel = WD_RDATA;
          cmd.idx_op = IDX_DEC;
        end else begin
          cmd.cnt_op  = CNT_INC;
          cmd.done    = 1'b1;
          cmd.pos_sel = PS_IDX;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.cnt_op  = CNT_INC;
        cmd.done    = 1'b1;
        cmd.pos_sel = PS_IDX;
      end
      S_FND_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_IDX;
      end
      S_FND_CMP: begin
        if (stat.eq) begin
          cmd.pos_hold = 1'b1;
          if (!is_delete_r) begin
            cmd.done    = 1'b1;
            cmd.pos_sel = PS_IDX;
          end else if (stat.last_scan) begin
            cmd.cnt_op  = CNT_DEC;
            cmd.done    = 1'b1;
            cmd.pos_sel = PS_IDX;
          end
        end else if (stat.last_scan) begin
          cmd.done   = 1'b1;
          cmd.status = STAT_NOTFOUND;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_DEL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_IDX_P1;
      end
      S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wd_sel = WD_RDATA;
        cmd.idx_op = IDX_INC;
        if (stat.last_move) begin
          cmd.cnt_op  = CNT_DEC;
          cmd.done    = 1'b1;
          cmd.pos_sel = PS_HELD;
        end
      end
      default: begin
        cmd.done = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/sle_dp.sv
// ----------------------------------------------------------------------------
// sle_dp
// datapath: entry ram, scan index, fill count, compare and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module sle_dp
  import sle_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [DATA_W-1:0]    in_value,
  input  wire cmd_t                 cmd,
  output stat_t                     stat,
  output logic                      out_strobe,
  output logic [1:0]                out_status,
  output logic [POS_W-1:0]          out_position,
  output logic [CNT_OUT_W-1:0]      out_entry_count
);

  logic [DATA_W-1:0]    value_r;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     pos_r;
  logic [CNT_W-1:0]     idx_m1, idx_p1, pos_src;
  logic [CNT_W:0]       idx_ext_p1;
  logic [CNT_W:0]       idx_ext_p2;
  logic [DATA_W-1:0]    cur_value, rd_data, wr_data;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;
  logic                 strobe_r;
  logic [1:0]           status_r;
  logic [POS_W-1:0]     position_r;
  logic [CNT_OUT_W-1:0] ecount_r;

  assign cur_value  = cmd.capture ? in_value : value_r;
  assign idx_m1     = idx_r - CNT_W'(1);
  assign idx_p1     = idx_r + CNT_W'(1);
  assign idx_ext_p1 = {1'b0, idx_r} + (CNT_W+1)'(1);
  assign idx_ext_p2 = {1'b0, idx_r} + (CNT_W+1)'(2);

  // scan index p is last when p + 1 equals the fill count
  // a shift-down step at p is last when p + 2 equals the fill count
  assign stat.full       = (count_r == CNT_W'(CAPACITY));
  assign stat.empty      = (count_r == '0);
  assign stat.gt         = ($signed(rd_data) > $signed(value_r));
  assign stat.eq         = (rd_data == value_r);
  assign stat.idx_is_one = (idx_r == CNT_W'(1));
  assign stat.last_scan  = (idx_ext_p1 == {1'b0, count_r});
  assign stat.last_move  = (idx_ext_p2 == {1'b0, count_r});

  always_comb begin
    unique case (cmd.rd_sel)
      RA_IDX_M1: rd_addr = idx_m1[ADDR_W-1:0];
      RA_IDX_P1: rd_addr = idx_p1[ADDR_W-1:0];
      default:   rd_addr = idx_r[ADDR_W-1:0];
    endcase
  end

  assign wr_addr = (cmd.wa_sel == WA_ZERO) ? '0 : idx_r[ADDR_W-1:0];
  assign wr_data = (cmd.wd_sel == WD_RDATA) ? rd_data : cur_value;

  sle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    unique case (cmd.idx_op)
      IDX_ZERO:  idx_nxt = '0;
      IDX_COUNT: idx_nxt = count_r;
      IDX_INC:   idx_nxt = idx_p1;
      IDX_DEC:   idx_nxt = idx_m1;
      default:   idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      CNT_CLEAR: count_nxt = '0;
      CNT_INC:   count_nxt = count_r + CNT_W'(1);
      CNT_DEC:   count_nxt = count_r - CNT_W'(1);
      default:   count_nxt = count_r;
    endcase
  end

  always_comb begin
    unique case (cmd.pos_sel)
      PS_IDX:  pos_src = idx_r;
      PS_HELD: pos_src = pos_r;
      default: pos_src = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.capture) begin
      value_r <= in_value;
    end
    if (cmd.pos_hold) begin
      pos_r <= idx_r;
    end
    if (cmd.done) begin
      status_r   <= cmd.status;
      position_r <= POS_W'(pos_src);
      ecount_r   <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_position    = position_r;
  assign out_entry_count = ecount_r;

endmodule

`default_nettype wire

>>> rtl/core/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// ascending list of signed 32-bit values with insert, search, delete, clear
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   --------------------------
//  input     in_opcode, in_value                     start high and busy low
//  result    out_status, out_position,               out_strobe, one cycle,
//            out_entry_count                         always taken
//
//  short: clear, insert into an empty or full list, and search or delete on
//    an empty list answer without leaving idle and keep busy low
//  insert: a read and a compare step per larger entry moved up, the value put
//    in the last compare or a put step; bound by the ram's registered read
//  search: a read and a compare step per entry scanned; delete adds a read
//    and a write step per entry moved down after the match
//  reset: synchronous, clears the fill count and the controller; the entry
//    ram is not cleared since only entries below the fill count are read
//  the result appears the cycle after the transaction's last step; the
//    receiver cannot stall, so nothing waits on the output side
//
`default_nettype none

module sorted_list_engine
  import sle_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_opcode,
  input  wire logic signed [31:0]    in_value,
  output logic                       out_strobe,
  output logic [1:0]                 out_status,
  output logic [6:0]                 out_position,
  output logic [7:0]                 out_entry_count
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  // value is carried as raw bits; the datapath does the signed compare
  sle_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

>>> rtl/core/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// port-level checks on the sorted list engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sle_checker
  import sle_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_opcode,
  input wire logic        out_strobe,
  input wire logic [1:0]  out_status,
  input wire logic [6:0]  out_position,
  input wire logic [7:0]  out_entry_count
);

  // clear answers on the next cycle with an empty list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_CLEAR) |=>
      (out_strobe && out_status == STAT_OK && out_entry_count == '0))
    else $error("clear did not report an empty list");

  // a long transaction ends with its result
  a_fell: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result");

  // failed operations report position zero
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != STAT_OK) |-> (out_position == '0))
    else $error("nonzero position on a failed transaction");

  // full status only at capacity, empty status only with no entries
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STAT_FULL) |-> (out_entry_count == 8'(CAPACITY)))
    else $error("full reported below capacity");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STAT_EMPTY) |-> (out_entry_count == '0))
    else $error("empty reported with entries present");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_opcode       (in_opcode),
  .out_strobe      (out_strobe),
  .out_status      (out_status),
  .out_position    (out_position),
  .out_entry_count (out_entry_count)
);

`default_nettype wire

>>> tb/sorted_list_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// self-checking bench for the sorted list: a short directed table, then long
// random runs of insert, search, delete and clear checked against a shadow
// copy of the list kept in the bench, under several sender idle patterns
// ----------------------------------------------------------------------------

module sorted_list_engine_tb;
  import sle_pkg::*;

  // one result transaction, field by field
  typedef struct packed {
    status_t    status;
    logic [6:0] position;
    logic [7:0] entry_count;
  } list_result_t;

  // one row of stimulus; typed rows carry their own expected result
  typedef struct packed {
    opcode_t            op;
    logic signed [31:0] value;
    logic               typed;
    list_result_t       res;
  } stim_row_t;

  // shapes of random bursts
  typedef enum {
    MODE_GROW,
    MODE_SHRINK,
    MODE_FILL,
    MODE_DRAIN
  } burst_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [1:0]         in_opcode = OP_INSERT;
  logic signed [31:0] in_value = '0;
  wire                busy;
  wire                out_strobe;
  wire [1:0]          out_status;
  wire [6:0]          out_position;
  wire [7:0]          out_entry_count;

  // expectation side-band, driven together with start so that the
  // scoreboard sees it with the same timing as the transaction itself
  logic               hint_typed = 1'b0;
  list_result_t       hint_res = '0;

  // shadow copy of the list contents, in ascending order
  logic signed [31:0] shadow_vals [0:CAPACITY-1];
  int                 shadow_cnt = 0;

  list_result_t       results_due [$];
  int                 mismatch_count = 0;
  int                 items_sent = 0;

  sorted_list_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // apply one operation to the shadow list and return what the block should
  // answer; insert lands after the last equal entry, search and delete act
  // on the first equal entry
  function automatic list_result_t apply_list_op(input opcode_t op,
                                                 input logic signed [31:0] v);
    list_result_t r;
    int           i;
    int           hit;
    r.status   = STAT_OK;
    r.position = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_cnt >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          i = shadow_cnt;
          while (i > 0 && shadow_vals[i-1] > v) begin
            shadow_vals[i] = shadow_vals[i-1];
            i--;
          end
          shadow_vals[i] = v;
          r.position = i[6:0];
          shadow_cnt++;
        end
      end
      OP_SEARCH, OP_DELETE: begin
        hit = -1;
        for (i = 0; i < shadow_cnt; i++)
          if (hit < 0 && shadow_vals[i] == v)
            hit = i;
        if (shadow_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else if (hit < 0) begin
          r.status = STAT_NOTFOUND;
        end else begin
          r.position = hit[6:0];
          if (op == OP_DELETE) begin
            for (i = hit; i + 1 < shadow_cnt; i++)
              shadow_vals[i] = shadow_vals[i+1];
            shadow_cnt--;
          end
        end
      end
      default: begin
        // clear
        shadow_cnt = 0;
      end
    endcase
    r.entry_count = shadow_cnt[7:0];
    return r;
  endfunction

  function automatic stim_row_t typed_row(input opcode_t op, input logic signed [31:0] v,
                                          input status_t st, input int pos, input int cnt);
    stim_row_t row;
    row.op                = op;
    row.value             = v;
    row.typed             = 1'b1;
    row.res.status        = st;
    row.res.position      = pos[6:0];
    row.res.entry_count   = cnt[7:0];
    return row;
  endfunction

  function automatic stim_row_t model_row(input opcode_t op, input logic signed [31:0] v);
    stim_row_t row;
    row       = '0;
    row.op    = op;
    row.value = v;
    return row;
  endfunction

  // values: mostly taken from the list or from a small pool so that hits and
  // duplicates are common, sometimes the extremes, sometimes anything
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40 && shadow_cnt > 0)
      return shadow_vals[$urandom_range(shadow_cnt - 1)];
    if (sel < 70)
      return int'($urandom_range(15)) - 8;
    if (sel < 78) begin
      case ($urandom_range(3))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return 32'sh0000_0000;
        default: return 32'shffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  function automatic opcode_t pick_op(input int ins_pct, input int srch_pct,
                                      input int del_pct);
    int r;
    r = $urandom_range(99);
    if (r < ins_pct)
      return OP_INSERT;
    if (r < ins_pct + srch_pct)
      return OP_SEARCH;
    if (r < ins_pct + srch_pct + del_pct)
      return OP_DELETE;
    return OP_CLEAR;
  endfunction

  // present one transaction and hold it until the block takes it; returns
  // at the accepting edge, so the caller may present the next one at once
  task automatic send_op(input stim_row_t row);
    in_opcode  <= row.op;
    in_value   <= row.value;
    hint_typed <= row.typed;
    hint_res   <= row.res;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // geometric run of idle cycles; the data lines carry junk meanwhile
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start     <= 1'b0;
      in_opcode <= 2'($urandom_range(3));
      in_value  <= $urandom();
      @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has come back; the first edge
  // lets the scoreboard log a transaction accepted at the calling edge
  task automatic wait_list_idle();
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  // scoreboard: results are checked first, since a result seen at an edge
  // always belongs to an earlier transaction than one accepted at that edge
  always @(posedge clk) begin : scoreboard
    list_result_t want;
    list_result_t predicted;
    if (rst_n) begin
      if (out_strobe) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing outstanding: status %0d position %0d count %0d",
                   $time, out_status, out_position, out_entry_count);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            mismatch_count++;
          end
          if (out_position !== want.position) begin
            $display("%0t: position expected %0d actual %0d",
                     $time, want.position, out_position);
            mismatch_count++;
          end
          if (out_entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, out_entry_count);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        // the shadow list always advances; typed rows override the answer
        predicted = apply_list_op(opcode_t'(in_opcode), in_value);
        results_due.push_back(hint_typed ? hint_res : predicted);
      end
    end
  end

  // generous fixed limit, several times the slowest legal run
  initial begin
    #(25_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   dir_rows [$];
    stim_row_t   row;
    burst_mode_t mode;
    int          phase;
    int          phase_end;
    int          gap_pct;
    int          burst_len;
    int          n;
    int          w;
    int          sel;
    int          idle_pct [4];

    // sender idle chance per phase; the third phase is the receiver-stall
    // phase, which has nothing to do here since results cannot be held off
    idle_pct[0] = 0;
    idle_pct[1] = 76;
    idle_pct[2] = 0;
    idle_pct[3] = 35;

    // directed table: empty list, extremes, duplicates, misses and clear
    dir_rows.push_back(typed_row(OP_SEARCH, 32'sd0, STAT_EMPTY, 0, 0));
    dir_rows.push_back(typed_row(OP_DELETE, -32'sd1, STAT_EMPTY, 0, 0));
    dir_rows.push_back(typed_row(OP_INSERT, 32'sh7fff_ffff, STAT_OK, 0, 1));
    dir_rows.push_back(typed_row(OP_INSERT, 32'sh8000_0000, STAT_OK, 0, 2));
    dir_rows.push_back(model_row(OP_INSERT, 32'sd0));
    dir_rows.push_back(model_row(OP_INSERT, 32'sd0));
    dir_rows.push_back(model_row(OP_INSERT, 32'sd0));
    dir_rows.push_back(model_row(OP_INSERT, -32'sd5));
    dir_rows.push_back(model_row(OP_INSERT, 32'sd100));
    dir_rows.push_back(model_row(OP_SEARCH, 32'sd0));
    dir_rows.push_back(model_row(OP_SEARCH, 32'sh7fff_ffff));
    dir_rows.push_back(model_row(OP_SEARCH, 32'sh8000_0000));
    dir_rows.push_back(model_row(OP_SEARCH, 32'sd7));
    dir_rows.push_back(model_row(OP_DELETE, 32'sd0));
    dir_rows.push_back(model_row(OP_DELETE, 32'sh8000_0000));
    dir_rows.push_back(model_row(OP_DELETE, 32'sh7fff_ffff));
    dir_rows.push_back(model_row(OP_DELETE, 32'sd42));
    dir_rows.push_back(model_row(OP_INSERT, 32'sh5555_5555));
    dir_rows.push_back(model_row(OP_INSERT, 32'shaaaa_aaaa));
    dir_rows.push_back(typed_row(OP_CLEAR, 32'sd0, STAT_OK, 0, 0));
    dir_rows.push_back(typed_row(OP_SEARCH, 32'sd0, STAT_EMPTY, 0, 0));
    dir_rows.push_back(typed_row(OP_DELETE, 32'sd0, STAT_EMPTY, 0, 0));
    dir_rows.push_back(typed_row(OP_INSERT, -32'sd1, STAT_OK, 0, 1));
    dir_rows.push_back(typed_row(OP_DELETE, -32'sd1, STAT_OK, 0, 0));
    dir_rows.push_back(typed_row(OP_CLEAR, -32'sd1, STAT_OK, 0, 0));

    // reset held at the start, released once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed transactions back to back
    foreach (dir_rows[i])
      send_op(dir_rows[i]);
    wait_list_idle();

    // random part in four idle phases
    for (phase = 0; phase < 4; phase++) begin
      phase_end = items_sent + 380;
      n = 0;
      while (items_sent < phase_end) begin
        // fill to capacity early in the first and last phase
        sel = $urandom_range(99);
        if ((phase == 0 || phase == 3) && n == 0)
          mode = MODE_FILL;
        else if (sel < 10)
          mode = MODE_FILL;
        else if (sel < 20)
          mode = MODE_DRAIN;
        else if (sel < 60)
          mode = MODE_GROW;
        else
          mode = MODE_SHRINK;
        n++;

        // some bursts run with no idling at all
        gap_pct = ($urandom_range(3) == 0) ? 0 : idle_pct[phase];

        case (mode)
          MODE_FILL: begin
            // insert until full, then hit the full limit a few times
            while (shadow_cnt < CAPACITY) begin
              send_op(model_row(OP_INSERT, pick_value()));
              idle_gap(gap_pct);
            end
            repeat (3) begin
              send_op(model_row(OP_INSERT, pick_value()));
              idle_gap(gap_pct);
            end
            repeat (2) begin
              send_op(model_row(OP_SEARCH, pick_value()));
              idle_gap(gap_pct);
            end
          end
          MODE_DRAIN: begin
            // remove stored values until empty, then poke the empty list
            while (shadow_cnt > 0) begin
              send_op(model_row(OP_DELETE, shadow_vals[$urandom_range(shadow_cnt - 1)]));
              idle_gap(gap_pct);
            end
            send_op(model_row(OP_SEARCH, pick_value()));
            idle_gap(gap_pct);
            send_op(model_row(OP_DELETE, pick_value()));
            idle_gap(gap_pct);
          end
          default: begin
            burst_len = $urandom_range(60, 15);
            repeat (burst_len) begin
              if (mode == MODE_GROW)
                row = model_row(pick_op(60, 22, 16), pick_value());
              else
                row = model_row(pick_op(20, 22, 56), pick_value());
              send_op(row);
              idle_gap(gap_pct);
            end
          end
        endcase

        // now and then let the list go quiet before going on
        if ($urandom_range(99) < 5)
          wait_list_idle();
      end
      wait_list_idle();
    end

    // drain: wait out what is still owed, then watch for stray results
    start <= 1'b0;
    for (w = 0; w < 4000 && results_due.size() != 0; w++)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, results_due.size());
      mismatch_count++;
    end

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sle_pkg.sv
rtl/core/sle_ram.sv
rtl/core/sle_ctrl.sv
rtl/core/sle_dp.sv
rtl/core/sorted_list_engine.sv
rtl/core/sle_checker.sv
tb/sorted_list_engine_tb.sv
